// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// plain invariant
`define CHK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

// File: sv/dmpp_pkg.sv
// ----------------------------------------------------------------------------
// dmpp_pkg
// types and constants shared by the packet parser controller and datapath
// ----------------------------------------------------------------------------
package dmpp_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  localparam logic [BYTE_W-1:0] SYNC_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] SYNC_M      = 8'h4D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOLLAR,
    ST_M,
    ST_SIZE,
    ST_BODY,
    ST_READ,
    ST_PUSH,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic load_size;
    logic load_type;
    logic store_byte;
    logic emit_start;
    logic read_byte;
    logic push_out;
    logic push_empty;
  } cmd_t;

  typedef struct packed {
    logic is_dollar;
    logic is_m;
    logic size_ok;
    logic fill_done;
    logic csum_ok;
    logic size_zero;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/dmpp_ctrl.sv
// ----------------------------------------------------------------------------
// dmpp_ctrl
// frame state machine: header, body capture and message emission sequencing
// ----------------------------------------------------------------------------
module dmpp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dmpp_pkg::sts_t sts,
  output dmpp_pkg::cmd_t cmd
);
  import dmpp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    accept    = 1'b0;
    case (state_r)
      ST_IDLE, ST_DOLLAR, ST_M, ST_SIZE, ST_BODY: begin
        in_ready = 1'b1;
        accept   = in_valid;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    case (state_r)
      ST_IDLE: begin
        if (accept && sts.is_dollar) state_nxt = ST_DOLLAR;
      end
      ST_DOLLAR: begin
        if (accept) state_nxt = sts.is_m ? ST_M : ST_IDLE;
      end
      ST_M: begin
        if (accept) begin
          if (sts.size_ok) begin
            cmd.load_size = 1'b1;
            state_nxt     = ST_SIZE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SIZE: begin
        if (accept) begin
          cmd.load_type = 1'b1;
          state_nxt     = ST_BODY;
        end
      end
      ST_BODY: begin
        if (accept) begin
          if (!sts.fill_done) begin
            cmd.store_byte = 1'b1;
          end else if (!sts.csum_ok) begin
            state_nxt = ST_IDLE;
          end else if (sts.size_zero) begin
            state_nxt = ST_EMPTY;
          end else begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.read_byte = 1'b1;
        state_nxt     = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push_out = 1'b1;
          state_nxt    = sts.emit_last ? ST_IDLE : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.push_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/dmpp_dp.sv
// ----------------------------------------------------------------------------
// dmpp_dp
// frame datapath: size, type and checksum registers, payload buffer, result register
// ----------------------------------------------------------------------------
module dmpp_dp #(
  parameter int PAYLOAD_MAX = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dmpp_pkg::BYTE_W-1:0] in_rx_byte,
  input  dmpp_pkg::cmd_t             cmd,
  output dmpp_pkg::sts_t             sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [dmpp_pkg::BYTE_W-1:0] out_msg_type,
  output logic [dmpp_pkg::BYTE_W-1:0] out_payload_byte,
  output logic [dmpp_pkg::IDX_W-1:0]  out_payload_index,
  output logic [dmpp_pkg::CNT_W-1:0]  out_payload_count,
  output logic                       out_has_payload,
  output logic                       out_last
);
  import dmpp_pkg::*;

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam logic [BYTE_W-1:0] MAX_SIZE = BYTE_W'(PAYLOAD_MAX);

  logic [BYTE_W-1:0] mem [PAYLOAD_MAX];

  logic [BYTE_W-1:0] size_r;
  logic [BYTE_W-1:0] xor_r;
  logic [BYTE_W-1:0] fill_r;
  logic [BYTE_W-1:0] type_r;
  logic [BYTE_W-1:0] idx_r;
  logic [BYTE_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_msg_type_r;
  logic [BYTE_W-1:0] out_payload_byte_r;
  logic [IDX_W-1:0]  out_payload_index_r;
  logic [CNT_W-1:0]  out_payload_count_r;
  logic              out_has_payload_r;
  logic              out_last_r;

  always_comb begin
    sts.is_dollar = (in_rx_byte == SYNC_DOLLAR);
    sts.is_m      = (in_rx_byte == SYNC_M);
    sts.size_ok   = (in_rx_byte <= MAX_SIZE);
    sts.fill_done = (fill_r == size_r);
    sts.csum_ok   = (xor_r == in_rx_byte);
    sts.size_zero = (size_r == '0);
    sts.emit_last = (({1'b0, idx_r} + (BYTE_W+1)'(1)) == {1'b0, size_r});
    sts.out_free  = !out_valid_r || out_ready;
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      xor_r  <= '0;
      fill_r <= '0;
      type_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.load_size) begin
        size_r <= in_rx_byte;
        xor_r  <= in_rx_byte;
        fill_r <= '0;
      end
      if (cmd.load_type) begin
        type_r <= in_rx_byte;
        xor_r  <= xor_r ^ in_rx_byte;
      end
      if (cmd.store_byte) begin
        xor_r  <= xor_r ^ in_rx_byte;
        fill_r <= fill_r + BYTE_W'(1);
      end
      if (cmd.emit_start) begin
        idx_r <= '0;
      end
      if (cmd.push_out) begin
        idx_r <= idx_r + BYTE_W'(1);
      end
    end
  end

  // payload buffer
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      mem[fill_r[AW-1:0]] <= in_rx_byte;
    end
    if (cmd.read_byte) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_out || cmd.push_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      out_msg_type_r      <= type_r;
      out_payload_byte_r  <= rd_data_r;
      out_payload_index_r <= idx_r[IDX_W-1:0];
      out_payload_count_r <= size_r[CNT_W-1:0];
      out_has_payload_r   <= 1'b1;
      out_last_r          <= sts.emit_last;
    end else if (cmd.push_empty) begin
      out_msg_type_r      <= type_r;
      out_payload_byte_r  <= '0;
      out_payload_index_r <= '0;
      out_payload_count_r <= '0;
      out_has_payload_r   <= 1'b0;
      out_last_r          <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_msg_type      = out_msg_type_r;
  assign out_payload_byte  = out_payload_byte_r;
  assign out_payload_index = out_payload_index_r;
  assign out_payload_count = out_payload_count_r;
  assign out_has_payload   = out_has_payload_r;
  assign out_last          = out_last_r;

endmodule

// File: sv/dollar_m_packet_parser.sv
// ----------------------------------------------------------------------------
// dollar_m_packet_parser
// deframes '$' 'M' size type payload checksum packets, one byte per transaction
//
//   channel  direction  handshake             payload
//   in_      input      in_valid/in_ready     in_rx_byte
//   out_     output     out_valid/out_ready   msg_type, payload_byte/index/count,
//                                             has_payload, last
//
// in_ready stays high through header and body bytes
// a good frame of n bytes emits n results, each by a buffer read and then a
// result register load; an empty frame emits one result
// input is not taken while a message is being emitted
// synchronous active-low reset clears the state machine and the result valid
// a stalled out_ready holds the emission sequence in place
// ----------------------------------------------------------------------------
module dollar_m_packet_parser #(
  parameter int PAYLOAD_MAX = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dmpp_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dmpp_pkg::BYTE_W-1:0] out_msg_type,
  output logic [dmpp_pkg::BYTE_W-1:0] out_payload_byte,
  output logic [dmpp_pkg::IDX_W-1:0]  out_payload_index,
  output logic [dmpp_pkg::CNT_W-1:0]  out_payload_count,
  output logic                       out_has_payload,
  output logic                       out_last
);
  import dmpp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dmpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmpp_dp #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_msg_type      (out_msg_type),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_payload_count (out_payload_count),
    .out_has_payload   (out_has_payload),
    .out_last          (out_last)
  );

`include "assert_macros.svh"

  `CHK_ALWAYS(a_cmd_onehot, $onehot0(cmd))
  `CHK_IMPLY(a_no_input_on_push, cmd.push_out || cmd.push_empty, !in_ready)
  `CHK_IMPLY(a_empty_shape, out_valid && !out_has_payload,
             out_last && (out_payload_count == '0) && (out_payload_byte == '0))
  `CHK_NEXT(a_push_sets_valid, cmd.push_out || cmd.push_empty, out_valid)

endmodule

// File: tb/tb_dollar_m_packet_parser.sv
// ----------------------------------------------------------------------------
// tb_dollar_m_packet_parser
// self-checking bench for the dollar-m packet deframer: bytes go in one
// transaction at a time, a bit-exact deframer model predicts the message
// results, and every result transaction is checked field by field in order.
// directed frames cover empty payloads, 00 and FF payload bytes, oversize, bad header,
// bad checksum and noise; random traffic then runs under four idle/stall mixes
// ----------------------------------------------------------------------------
module tb_dollar_m_packet_parser;
  import dmpp_pkg::*;

  localparam int PAYLOAD_MAX      = 64;
  localparam int ITEMS_PER_PHASE  = 45;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CLK_PERIOD       = 12;
  localparam int RUN_LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_type;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  index;
    logic [CNT_W-1:0]  count;
    logic              has_data;
    logic              last;
  } msg_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_msg_type;
  logic [BYTE_W-1:0]   out_payload_byte;
  logic [IDX_W-1:0]    out_payload_index;
  logic [CNT_W-1:0]    out_payload_count;
  logic                out_has_payload;
  logic                out_last;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int frames_closed  = 0;
  int frame_items    = 0;

  // deframer model state
  state_t            parse_st = ST_IDLE;
  logic [CNT_W-1:0]  frame_size = '0;
  logic [BYTE_W-1:0] frame_csum = '0;
  int                fill_cnt = 0;
  logic [BYTE_W-1:0] frame_type = '0;
  logic [BYTE_W-1:0] frame_buf [PAYLOAD_MAX];
  msg_result_t       expected_msgs [$];

  logic [BYTE_W-1:0] body_bytes [PAYLOAD_MAX];

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  dollar_m_packet_parser #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_msg_type     (out_msg_type),
    .out_payload_byte (out_payload_byte),
    .out_payload_index(out_payload_index),
    .out_payload_count(out_payload_count),
    .out_has_payload  (out_has_payload),
    .out_last         (out_last)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    msg_result_t r;
    case (parse_st)
      ST_IDLE: begin
        if (b == SYNC_DOLLAR) parse_st = ST_DOLLAR;
      end
      ST_DOLLAR: begin
        parse_st = (b == SYNC_M) ? ST_M : ST_IDLE;
      end
      ST_M: begin
        if (int'(b) > PAYLOAD_MAX) begin
          parse_st = ST_IDLE;
        end else begin
          frame_size = b[CNT_W-1:0];
          frame_csum = b;
          fill_cnt   = 0;
          parse_st   = ST_SIZE;
        end
      end
      ST_SIZE: begin
        frame_type = b;
        frame_csum ^= b;
        parse_st   = ST_BODY;
      end
      ST_BODY: begin
        if (fill_cnt < int'(frame_size)) begin
          frame_csum ^= b;
          frame_buf[fill_cnt] = b;
          fill_cnt++;
        end else begin
          if (frame_csum == b) begin
            frames_closed++;
            if (frame_size == 0) begin
              r = '{msg_type: frame_type, data: '0, index: '0, count: '0,
                    has_data: 1'b0, last: 1'b1};
              expected_msgs.push_back(r);
            end else begin
              for (int k = 0; k < int'(frame_size); k++) begin
                r = '{msg_type: frame_type, data: frame_buf[k], index: k[IDX_W-1:0],
                      count: frame_size, has_data: 1'b1,
                      last: (k + 1 == int'(frame_size))};
                expected_msgs.push_back(r);
              end
            end
          end
          parse_st = ST_IDLE;
        end
      end
      default: parse_st = ST_IDLE;
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] mtype, input int size,
                            input bit bad_csum);
    logic [BYTE_W-1:0] csum;
    csum = size[BYTE_W-1:0] ^ mtype;
    send_byte(SYNC_DOLLAR);
    send_byte(SYNC_M);
    send_byte(size[BYTE_W-1:0]);
    send_byte(mtype);
    for (int i = 0; i < size; i++) begin
      csum ^= body_bytes[i];
      send_byte(body_bytes[i]);
    end
    if (bad_csum) csum ^= (8'h01 << $urandom_range(BYTE_W - 1));
    send_byte(csum);
    frame_items += size + 5;
  endtask

  task automatic test_empty_message();
    send_frame(8'h00, 0, 1'b0);
  endtask

  task automatic test_payload_extremes();
    body_bytes[0] = 8'h00;
    body_bytes[1] = 8'hFF;
    send_frame(8'hFF, 2, 1'b0);
  endtask

  task automatic test_oversized_frame();
    send_byte(SYNC_DOLLAR);
    send_byte(SYNC_M);
    send_byte(8'(PAYLOAD_MAX + 1));
  endtask

  task automatic test_bad_header();
    // the second dollar only drops back to idle, so the m after it is noise
    send_byte(SYNC_DOLLAR);
    send_byte(SYNC_DOLLAR);
    send_byte(SYNC_M);
  endtask

  task automatic test_bad_checksum();
    body_bytes[0] = 8'($urandom_range(255));
    send_frame(8'h5A, 1, 1'b1);
  endtask

  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct);
    int pick;
    int size;
    int noise_n;
    logic [BYTE_W-1:0] b;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    frame_items    = 0;
    while (frame_items < ITEMS_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        size = $urandom_range(99);
        if (size < 4) size = PAYLOAD_MAX;
        else if (size < 20) size = $urandom_range(PAYLOAD_MAX);
        else size = $urandom_range(6);
        for (int i = 0; i < size; i++) body_bytes[i] = 8'($urandom_range(255));
        send_frame(8'($urandom_range(255)), size, pick >= 65);
      end else if (pick < 83) begin
        send_byte(SYNC_DOLLAR);
        send_byte(SYNC_M);
        send_byte(8'($urandom_range(PAYLOAD_MAX + 1, 255)));
        frame_items += 3;
      end else if (pick < 91) begin
        b = 8'($urandom_range(255));
        if (b == SYNC_M) b = ~b;
        send_byte(SYNC_DOLLAR);
        send_byte(b);
        frame_items += 2;
      end else begin
        noise_n = $urandom_range(1, 3);
        repeat (noise_n) send_byte(8'($urandom_range(255)));
        frame_items += noise_n;
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    msg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_msgs.size() == 0) begin
        report_mismatch($sformatf("result with none expected (type %0h index %0d)",
                                  out_msg_type, out_payload_index));
      end else begin
        want = expected_msgs.pop_front();
        if (out_msg_type !== want.msg_type)
          report_mismatch($sformatf("msg_type got %0h want %0h",
                                    out_msg_type, want.msg_type));
        if (out_payload_byte !== want.data)
          report_mismatch($sformatf("payload_byte got %0h want %0h",
                                    out_payload_byte, want.data));
        if (out_payload_index !== want.index)
          report_mismatch($sformatf("payload_index got %0d want %0d",
                                    out_payload_index, want.index));
        if (out_payload_count !== want.count)
          report_mismatch($sformatf("payload_count got %0d want %0d",
                                    out_payload_count, want.count));
        if (out_has_payload !== want.has_data)
          report_mismatch($sformatf("has_payload got %0b want %0b",
                                    out_has_payload, want.has_data));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
      end
      results_seen++;
    end
  end

  initial begin
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_dollar_m_packet_parser NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_payload_extremes();
    test_oversized_frame();
    test_bad_header();
    test_bad_checksum();
    test_idle_noise();

    test_random_traffic(0, 0);
    test_random_traffic(75, 0);
    test_random_traffic(0, 75);
    test_random_traffic(36, 36);

    in_valid <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("frames delivered: %0d, result transactions checked: %0d", frames_closed,
             results_seen);
    $display("traffic mixed good, oversize, bad-header and bad-checksum frames with noise");
    if (mismatches == 0) begin
      $display("tb_dollar_m_packet_parser OK");
    end else begin
      $display("tb_dollar_m_packet_parser NOT OK");
    end
    $finish;
  end

endmodule

// File: dollar_m_packet_parser.f
+incdir+sv
sv/dmpp_pkg.sv
sv/dmpp_ctrl.sv
sv/dmpp_dp.sv
sv/dollar_m_packet_parser.sv
tb/tb_dollar_m_packet_parser.sv
